// ===== rtl/core/lvsp_pkg.sv =====
`timescale 1ns / 1ps

package lvsp_pkg;

  // table geometry
  localparam int ENTRIES     = 1024;
  localparam int THREAD_BITS = 2;
  localparam int PC_SHIFT    = 0;

  localparam int IDX_W    = $clog2(ENTRIES);
  // floor(log2(ENTRIES)), also right for sizes that are not a power of two
  localparam int IDX_LOG  = $clog2(ENTRIES + 1) - 1;
  localparam int TH_SHIFT = (IDX_LOG > THREAD_BITS) ? IDX_LOG - THREAD_BITS : 0;
  localparam logic [63:0] IDX_MASK = 64'(ENTRIES - 1);

  typedef logic [1:0]  op_t;
  typedef logic [1:0]  thread_t;
  typedef logic [63:0] value_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam op_t OP_LAST   = 2'd0;
  localparam op_t OP_STRIDE = 2'd1;
  localparam op_t OP_UPDATE = 2'd2;
  localparam op_t OP_INVAL  = 2'd3;

  typedef struct packed {
    thread_t thread;
    logic    valid;
  } flag_t;

  typedef struct packed {
    value_t newest;
    value_t previous;
  } hist_t;

endpackage

// ===== rtl/core/lvsp_ram.sv =====
`timescale 1ns / 1ps

module lvsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/load_value_stride_predictor.sv =====
`timescale 1ns / 1ps
// A word reads the tables in stage 1, waits while m_* stalls, then moves to m_*.
// Throughput: one word per cycle unless m_* stalls or a sweep runs, set by the
// single read and write port of the tables. Invalidate-all: after its result,
// s_tready stays low while the valid bits are swept one entry a cycle.
// Reset (rst, synchronous): a clearing pass zeroes every entry; s_tready is low
// until it ends.

module load_value_stride_predictor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // pc[63:0], thread[65:64], value[129:66], zero fill
  input  logic [1:0]   s_tuser,   // op[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // prediction[63:0], stride[127:64]
  output logic [0:0]   m_tuser    // hit[0]
);

  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_CLR_ALL   = 2'd1;
  localparam logic [1:0] ST_CLR_VALID = 2'd2;

  logic [1:0] state, state_next;
  lvsp_pkg::idx_t clr_idx;

  // input fields
  lvsp_pkg::op_t     in_op;
  logic [63:0]       in_pc;
  lvsp_pkg::thread_t in_thread;
  lvsp_pkg::value_t  in_value;
  logic [63:0]       idx_full;
  lvsp_pkg::idx_t    in_idx;

  assign in_op     = s_tuser;
  assign in_pc     = s_tdata[63:0];
  assign in_thread = s_tdata[65:64];
  assign in_value  = s_tdata[129:66];

  assign idx_full = ((in_pc >> lvsp_pkg::PC_SHIFT)
                     ^ (64'(in_thread) << lvsp_pkg::TH_SHIFT)) & lvsp_pkg::IDX_MASK;
  assign in_idx   = idx_full[lvsp_pkg::IDX_W-1:0];

  // stage 1 registers
  logic              s1_valid;
  lvsp_pkg::op_t     s1_op;
  lvsp_pkg::idx_t    s1_idx;
  lvsp_pkg::thread_t s1_thread;
  lvsp_pkg::value_t  s1_value;

  logic accept, adv, s1_hold, sweeping;

  assign sweeping = (state != ST_RUN);
  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s1_hold  = s1_valid && !adv;
  // no new word may read the tables in the cycle an invalidate hands off
  assign s_tready = !sweeping && (!s1_valid || (adv && s1_op != lvsp_pkg::OP_INVAL));
  assign accept   = s_tvalid && s_tready;

  // table ports
  lvsp_pkg::idx_t  rd_addr;
  lvsp_pkg::flag_t flag_rdata, flag_wdata;
  lvsp_pkg::hist_t hist_rdata, hist_wdata;
  lvsp_pkg::idx_t  wr_addr;
  logic            flag_we, hist_we, upd_wr;

  // a held word re-reads its own entry so the read data stays current
  assign rd_addr = s1_hold ? s1_idx : in_idx;

  // last update written, bypassed when a later word reads the same entry
  logic            wr_valid;
  lvsp_pkg::idx_t  wr_idx;
  lvsp_pkg::flag_t wr_flag;
  lvsp_pkg::hist_t wr_hist;

  logic            byp;
  lvsp_pkg::flag_t flag_cur;
  lvsp_pkg::hist_t hist_cur;
  logic            is_lookup, hit_c;
  lvsp_pkg::value_t stride_c, pred_c;

  assign byp      = wr_valid && (wr_idx == s1_idx);
  assign flag_cur = byp ? wr_flag : flag_rdata;
  assign hist_cur = byp ? wr_hist : hist_rdata;

  assign is_lookup = (s1_op == lvsp_pkg::OP_LAST) || (s1_op == lvsp_pkg::OP_STRIDE);
  assign hit_c     = is_lookup && flag_cur.valid && (flag_cur.thread == s1_thread);
  assign stride_c  = hist_cur.newest - hist_cur.previous;

  // newest + (newest - previous) folded into one subtract; OP_LAST or a zero previous gives newest
  always_comb begin
    if (s1_op == lvsp_pkg::OP_LAST || hist_cur.previous == '0) begin
      pred_c = hist_cur.newest;
    end else begin
      pred_c = {hist_cur.newest[62:0], 1'b0} - hist_cur.previous;
    end
  end

  assign upd_wr     = adv && (s1_op == lvsp_pkg::OP_UPDATE);
  assign flag_we    = sweeping || upd_wr;
  assign hist_we    = (state == ST_CLR_ALL) || upd_wr;
  assign wr_addr    = sweeping ? clr_idx : s1_idx;
  assign flag_wdata = sweeping ? '0 : lvsp_pkg::flag_t'{thread: s1_thread, valid: 1'b1};
  assign hist_wdata = sweeping ? '0
                               : lvsp_pkg::hist_t'{newest: s1_value,
                                                   previous: hist_cur.newest};

  lvsp_ram #(
    .WIDTH ($bits(lvsp_pkg::flag_t)),
    .DEPTH (lvsp_pkg::ENTRIES)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (wr_addr),
    .wdata (flag_wdata),
    .raddr (rd_addr),
    .rdata (flag_rdata)
  );

  lvsp_ram #(
    .WIDTH ($bits(lvsp_pkg::hist_t)),
    .DEPTH (lvsp_pkg::ENTRIES)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wr_addr),
    .wdata (hist_wdata),
    .raddr (rd_addr),
    .rdata (hist_rdata)
  );

  // sweep control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (adv && s1_op == lvsp_pkg::OP_INVAL) begin
          state_next = ST_CLR_VALID;
        end
      end
      ST_CLR_ALL, ST_CLR_VALID: begin
        if (clr_idx == lvsp_pkg::IDX_W'(lvsp_pkg::ENTRIES - 1)) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR_ALL;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (sweeping && state_next != ST_RUN) begin
        clr_idx <= clr_idx + 1'b1;
      end else begin
        clr_idx <= '0;
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= in_op;
      s1_idx    <= in_idx;
      s1_thread <= in_thread;
      s1_value  <= in_value;
    end
  end

  // bypass register
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (sweeping) begin
      wr_valid <= 1'b0;
    end else if (upd_wr) begin
      wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_wr) begin
      wr_idx  <= s1_idx;
      wr_flag <= flag_wdata;
      wr_hist <= hist_wdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tuser[0]      <= hit_c;
      m_tdata[63:0]   <= hit_c ? pred_c : '0;
      m_tdata[127:64] <= hit_c ? stride_c : '0;
    end
  end

  // checks
  a_inval_sweeps: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_op == lvsp_pkg::OP_INVAL) |=> (state == ST_CLR_VALID))
    else $error("invalidate did not start the valid sweep");

  a_sweep_empty: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !s1_valid)
    else $error("word in flight during a table sweep");

  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=> (s1_valid && $stable(s1_idx)))
    else $error("stalled word lost its table entry");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("result without hit carries nonzero data");

endmodule
